@@ hdl/q24_alu_pkg.sv @@
package q24_alu_pkg;

  localparam int unsigned FractionBitsDefault = 8;
  localparam int unsigned WordBitsDefault     = 32;
  localparam int unsigned ActionBits          = 4;
  localparam int unsigned QueueDepth          = 2;

  typedef enum logic [ActionBits-1:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_MIN      = 4'd4,
    ACT_MAX      = 4'd5,
    ACT_CMP      = 4'd6,
    ACT_INC      = 4'd7,
    ACT_DEC      = 4'd8,
    ACT_FROM_INT = 4'd9,
    ACT_TO_INT   = 4'd10
  } action_e;

  // Operation class picked by the front end.
  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } class_e;

  typedef struct packed {
    logic greater;
    logic less;
    logic equal;
  } cmp_flags_t;

endpackage

@@ hdl/q24_alu_front.sv @@
module q24_alu_front #(
  parameter int unsigned WordBits     = q24_alu_pkg::WordBitsDefault,
  parameter int unsigned FractionBits = q24_alu_pkg::FractionBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [q24_alu_pkg::ActionBits-1:0]     action_i,
  input  logic signed [WordBits-1:0]             operand_a_i,
  input  logic signed [WordBits-1:0]             operand_b_i,
  output logic                                   q_valid_o,
  input  logic                                   q_stall_i,
  output q24_alu_pkg::class_e                    q_class_o,
  output logic signed [WordBits-1:0]             q_a_o,
  output logic signed [WordBits-1:0]             q_b_o,
  output q24_alu_pkg::cmp_flags_t                q_flags_o,
  output logic [WordBits-1:0]                    q_simple_o,
  output logic                                   q_sat_o
);

  localparam int unsigned Depth = q24_alu_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned W     = WordBits;
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    q24_alu_pkg::class_e                cls;
    logic [W-1:0]                       a;
    logic [W-1:0]                       b;
    q24_alu_pkg::cmp_flags_t            flags;
    logic [W-1:0]                       simple;
    logic                               sat;
  } entry_t;

  entry_t              ent_d;
  entry_t              mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;
  logic                push, pop;

  // Classify and compute the simple actions.
  always_comb begin
    logic [W:0] sum;
    logic [W:0] dif;
    logic       ovf;
    logic       a_neg;
    ent_d        = '0;
    ent_d.a      = operand_a_i;
    ent_d.b      = operand_b_i;
    ent_d.cls    = q24_alu_pkg::CLS_SIMPLE;
    ent_d.flags.greater = operand_a_i > operand_b_i;
    ent_d.flags.less    = operand_a_i < operand_b_i;
    ent_d.flags.equal   = operand_a_i == operand_b_i;
    sum   = {operand_a_i[W-1], operand_a_i} + {operand_b_i[W-1], operand_b_i};
    dif   = {operand_a_i[W-1], operand_a_i} - {operand_b_i[W-1], operand_b_i};
    a_neg = operand_a_i[W-1];
    ovf   = 1'b0;
    unique case (action_i)
      q24_alu_pkg::ACT_ADD: begin
        if (sum[W] != sum[W-1]) begin
          ent_d.sat = 1'b1;
          ent_d.simple = a_neg ? MinNeg : MaxPos;
        end else begin
          ent_d.simple = sum[W-1:0];
        end
      end
      q24_alu_pkg::ACT_SUB: begin
        if (dif[W] != dif[W-1]) begin
          ent_d.sat = 1'b1;
          ent_d.simple = a_neg ? MinNeg : MaxPos;
        end else begin
          ent_d.simple = dif[W-1:0];
        end
      end
      q24_alu_pkg::ACT_MUL: ent_d.cls = q24_alu_pkg::CLS_MUL;
      q24_alu_pkg::ACT_DIV: ent_d.cls = q24_alu_pkg::CLS_DIV;
      q24_alu_pkg::ACT_MIN:
        ent_d.simple = ent_d.flags.greater ? operand_b_i : operand_a_i;
      q24_alu_pkg::ACT_MAX:
        ent_d.simple = ent_d.flags.greater ? operand_a_i : operand_b_i;
      q24_alu_pkg::ACT_INC: begin
        ent_d.sat    = operand_a_i == MaxPos;
        ent_d.simple = ent_d.sat ? MaxPos : operand_a_i + 1'b1;
      end
      q24_alu_pkg::ACT_DEC: begin
        ent_d.sat    = operand_a_i == MinNeg;
        ent_d.simple = ent_d.sat ? MinNeg : operand_a_i - 1'b1;
      end
      q24_alu_pkg::ACT_FROM_INT: begin
        // Top FractionBits+1 bits must all match the sign.
        ovf = (operand_a_i[W-1 -: FractionBits+1] != {(FractionBits+1){1'b0}}) &&
              (operand_a_i[W-1 -: FractionBits+1] != {(FractionBits+1){1'b1}});
        ent_d.sat    = ovf;
        ent_d.simple = ovf ? (a_neg ? MinNeg : MaxPos) : (operand_a_i <<< FractionBits);
      end
      q24_alu_pkg::ACT_TO_INT: ent_d.simple = operand_a_i >>> FractionBits;
      default: ent_d.simple = '0;
    endcase
  end

  assign in_stall_o = (cnt_q == (PtrW+1)'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && !q_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= ent_d;
  end

  assign q_class_o  = mem_q[rd_q].cls;
  assign q_a_o      = mem_q[rd_q].a;
  assign q_b_o      = mem_q[rd_q].b;
  assign q_flags_o  = mem_q[rd_q].flags;
  assign q_simple_o = mem_q[rd_q].simple;
  assign q_sat_o    = mem_q[rd_q].sat;

endmodule

@@ hdl/q24_alu_back.sv @@
module q24_alu_back #(
  parameter int unsigned WordBits     = q24_alu_pkg::WordBitsDefault,
  parameter int unsigned FractionBits = q24_alu_pkg::FractionBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  output logic                               q_stall_o,
  input  q24_alu_pkg::class_e                q_class_i,
  input  logic signed [WordBits-1:0]         q_a_i,
  input  logic signed [WordBits-1:0]         q_b_i,
  input  q24_alu_pkg::cmp_flags_t            q_flags_i,
  input  logic [WordBits-1:0]                q_simple_i,
  input  logic                               q_sat_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [WordBits-1:0]         result_value_o,
  output q24_alu_pkg::cmp_flags_t            flags_o,
  output logic                               divide_by_zero_o,
  output logic                               saturated_o
);

  // Pipelined back end. Stage 0 takes magnitudes, then one quotient bit per
  // stage, then a trailing stage whose result is rounded and packed into the output register. Multiply runs alongside.
  localparam int unsigned W   = WordBits;
  localparam int unsigned F   = FractionBits;
  localparam int unsigned NB  = W + F;        // dividend bits, also quotient bits
  localparam int unsigned PW  = 2 * W;        // product width
  localparam int unsigned HW  = (W + 1) / 2;  // multiplier split
  localparam int unsigned NS  = NB + 2;       // total stages
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic                    valid;
    q24_alu_pkg::class_e     cls;
    logic                    neg;
    logic                    dz;
    q24_alu_pkg::cmp_flags_t flags;
    logic [W-1:0]            simple;
    logic                    sat;
    logic [W-1:0]            div;      // divisor magnitude
    logic [NB-1:0]           num;      // shifting dividend, becomes quotient
    logic [W:0]              rem;
    logic [PW-1:0]           prod;
  } stage_t;

  stage_t st_q [NS];
  stage_t st_d [NS];
  logic   advance;

  logic [W-1:0] out_val_q;
  q24_alu_pkg::cmp_flags_t out_flags_q;
  logic out_dz_q, out_sat_q, out_valid_q;

  logic [PW-1:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [PW-1:0] pp_lh_q, pp_hl_q;

  // Whole pipe moves when the output slot is free or being emptied.
  assign advance   = !out_valid_q || !out_stall_i;
  assign q_stall_o = !advance;

  always_comb begin
    logic [W-1:0] ma, mb;
    ma = q_a_i[W-1] ? W'(-q_a_i) : q_a_i;
    mb = q_b_i[W-1] ? W'(-q_b_i) : q_b_i;
    st_d[0]        = '0;
    st_d[0].valid  = q_valid_i;
    st_d[0].cls    = q_class_i;
    st_d[0].neg    = q_a_i[W-1] ^ q_b_i[W-1];
    st_d[0].dz     = (q_class_i == q24_alu_pkg::CLS_DIV) && (q_b_i == '0);
    st_d[0].flags  = q_flags_i;
    st_d[0].simple = q_simple_i;
    st_d[0].sat    = q_sat_i;
    st_d[0].div    = mb;
    st_d[0].num    = {ma, {F{1'b0}}};
    st_d[0].rem    = '0;
    st_d[0].prod   = {ma, mb};   // operand holder for the multiply stage
  end

  // Stage 1: multiply as four half products; low and high are summed into stage 1, the cross ones in stage 2.
  always_comb begin
    logic [W-1:0] xa, xb;
    xa = st_q[0].prod[PW-1:W];
    xb = st_q[0].prod[W-1:0];
    pp_ll = PW'(xa[HW-1:0]) * PW'(xb[HW-1:0]);
    pp_lh = PW'(xa[HW-1:0]) * PW'(xb[W-1:HW]);
    pp_hl = PW'(xa[W-1:HW]) * PW'(xb[HW-1:0]);
    pp_hh = PW'(xa[W-1:HW]) * PW'(xb[W-1:HW]);
  end

  // Restoring division, one quotient bit per stage up to NB; the last stage only passes through.
  for (genvar s = 1; s < NS; s++) begin : g_stage
    always_comb begin
      logic [W:0] trial;
      logic [W:0] rsh;
      st_d[s] = st_q[s-1];
      rsh   = {st_q[s-1].rem[W-1:0], st_q[s-1].num[NB-1]};
      trial = rsh - {1'b0, st_q[s-1].div};
      if (s <= NB) begin
        st_d[s].num = {st_q[s-1].num[NB-2:0], !trial[W]};
        st_d[s].rem = trial[W] ? rsh : trial;
      end
      if (s == 1) begin
        st_d[s].prod = pp_ll + (pp_hh << (2 * HW));
      end
      if (s == 2) begin
        st_d[s].prod = st_q[s-1].prod + ((pp_lh_q + pp_hl_q) << HW);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) st_q[i].valid <= 1'b0;
    end else if (advance) begin
      for (int i = 0; i < NS; i++) st_q[i] <= st_d[i];
      pp_lh_q <= pp_lh;
      pp_hl_q <= pp_hl;
    end
  end

  // Final stage: round, clamp, select.
  stage_t fin;
  assign fin = st_q[NS-1];

  logic [W-1:0] fin_val;
  logic         fin_sat;

  always_comb begin
    logic [PW:0]   pr;
    logic [PW:0]   pm;
    logic [NB:0]   qr;
    logic [W:0]    r2;
    logic [PW:0]   mag;
    logic [W-1:0]  val;
    logic          sat;
    logic [W-1:0]  lim;
    pr  = {1'b0, fin.prod} + (PW+1)'(1) * ((PW+1)'(1) << (F - 1));
    pm  = pr >> F;
    r2  = {fin.rem[W-1:0], 1'b0};
    qr  = {1'b0, fin.num} + (NB+1)'(r2 >= {1'b0, fin.div});
    mag = (fin.cls == q24_alu_pkg::CLS_MUL) ? pm : (PW+1)'(qr);
    lim = fin.neg ? MinNeg : MaxPos;
    val = fin.simple;
    sat = fin.sat;
    if (fin.cls != q24_alu_pkg::CLS_SIMPLE) begin
      if (fin.dz) begin
        val = '0;
        sat = 1'b0;
      end else if (mag > (PW+1)'(lim)) begin
        val = lim;
        sat = 1'b1;
      end else begin
        val = fin.neg ? W'(-mag[W-1:0]) : mag[W-1:0];
        sat = 1'b0;
      end
    end
    fin_val = val;
    fin_sat = sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_val_q   <= fin_val;
      out_flags_q <= fin.flags;
      out_dz_q    <= fin.dz;
      out_sat_q   <= fin_sat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_value_o   = out_val_q;
  assign flags_o          = out_flags_q;
  assign divide_by_zero_o = out_dz_q;
  assign saturated_o      = out_sat_q;

endmodule

@@ hdl/fixed_point_q24_8_alu_unit.sv @@
// Signed Q24.8 fixed-point ALU (generally Q(WordBits-FractionBits).FractionBits).
// One transaction carries an action and two raw operands and yields one result
// with greater/less/equal flags for a against b, a divide_by_zero flag and a
// saturated flag. Add, sub, mul and div round half away from zero and clamp to
// the signed word range. The block accepts one transaction per cycle while
// in_stall_o is low. Each transaction, in Q24.8 or any format, passes through
// the front-end queue, a stage taking operand magnitudes, one quotient bit per
// stage in the back end's divider pipeline, one trailing stage, and a
// registered output that takes the rounded and clamped result. Every action,
// cheap or not, goes through the same pipeline, so results leave in order. A
// two-entry queue between front and back lets either side stall on its own.
module fixed_point_q24_8_alu_unit #(
  parameter int unsigned WordBits     = q24_alu_pkg::WordBitsDefault,
  parameter int unsigned FractionBits = q24_alu_pkg::FractionBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [q24_alu_pkg::ActionBits-1:0] action_i,
  input  logic signed [WordBits-1:0]         operand_a_i,
  input  logic signed [WordBits-1:0]         operand_b_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [WordBits-1:0]         result_value_o,
  output logic                               a_greater_o,
  output logic                               a_less_o,
  output logic                               a_equal_o,
  output logic                               divide_by_zero_o,
  output logic                               saturated_o
);

  logic                                q_valid, q_stall, q_sat;
  q24_alu_pkg::class_e                 q_class;
  logic signed [WordBits-1:0]          q_a, q_b;
  q24_alu_pkg::cmp_flags_t             q_flags, out_flags;
  logic [WordBits-1:0]                 q_simple;

  // Front end: classify, handle simple actions, queue the transaction.
  q24_alu_front #(
    .WordBits     (WordBits),
    .FractionBits (FractionBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .q_valid_o   (q_valid),
    .q_stall_i   (q_stall),
    .q_class_o   (q_class),
    .q_a_o       (q_a),
    .q_b_o       (q_b),
    .q_flags_o   (q_flags),
    .q_simple_o  (q_simple),
    .q_sat_o     (q_sat)
  );

  // Back end: multiply and divide pipeline, rounding, clamp, output register.
  q24_alu_back #(
    .WordBits     (WordBits),
    .FractionBits (FractionBits)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_stall_o        (q_stall),
    .q_class_i        (q_class),
    .q_a_i            (q_a),
    .q_b_i            (q_b),
    .q_flags_i        (q_flags),
    .q_simple_i       (q_simple),
    .q_sat_i          (q_sat),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_value_o   (result_value_o),
    .flags_o          (out_flags),
    .divide_by_zero_o (divide_by_zero_o),
    .saturated_o      (saturated_o)
  );

  assign a_greater_o = out_flags.greater;
  assign a_less_o    = out_flags.less;
  assign a_equal_o   = out_flags.equal;

endmodule
